[hw/rtl/pdisp_pkg.sv]
// Package for the periodic task dispatcher.
// Sizes, operation and result codes, and controller/datapath command and status types.
// No dependencies.
package pdisp_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int SLOT_CAP   = (TASK_SLOTS < 8) ? TASK_SLOTS : 8;
   localparam int IDX_W      = 3;
   localparam int CNT_W      = 4;
   localparam int TIME_W     = 32;

   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_RUN      = 1'b1;

   localparam logic KIND_REG = 1'b0;
   localparam logic KIND_RUN = 1'b1;

   localparam logic STAT_OK     = 1'b0;
   localparam logic STAT_REJECT = 1'b1;

   typedef struct packed {
      logic capture;
      logic do_reg;
      logic scan_step;
      logic scan_finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_more;
   } stat_type;

endpackage

[hw/rtl/pdisp_if.sv]
// Valid/ready channel interfaces for the dispatcher request and response.
// Depends on pdisp_pkg.
interface pdisp_req_if
   import pdisp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              op;
   logic              callback_present;
   logic [TIME_W-1:0] period;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, op, callback_present, period, now_time, input ready);
   modport sink   (input valid, op, callback_present, period, now_time, output ready);
endinterface

interface pdisp_rsp_if
   import pdisp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic             status;
   logic [IDX_W-1:0] task_index;
   logic             due_valid;
   logic             last;

   modport source (output valid, kind, status, task_index, due_valid, last, input ready);
   modport sink   (input valid, kind, status, task_index, due_valid, last, output ready);
endinterface

[hw/rtl/pdisp_ctrl.sv]
// Dispatcher controller: sequences registration and run scans.
// Depends on pdisp_pkg; drives commands to pdisp_datapath.
module pdisp_ctrl
   import pdisp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_op,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_REG  = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_RUN) ? S_SCAN : S_REG;
            end
         end
         S_REG: begin
            if (stat.out_free) begin
               cmd.do_reg = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.out_free) begin
               if (stat.scan_more) begin
                  cmd.scan_step = 1'b1;
               end else begin
                  cmd.scan_finish = 1'b1;
                  state_in        = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/pdisp_datapath.sv]
// Dispatcher datapath: task tables, scan index, due test and response register.
// Depends on pdisp_pkg; commanded by pdisp_ctrl.
module pdisp_datapath
   import pdisp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              req_callback_present,
   input  logic [TIME_W-1:0] req_period,
   input  logic [TIME_W-1:0] req_now_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic              rsp_status,
   output logic [IDX_W-1:0]  rsp_task_index,
   output logic              rsp_due_valid,
   output logic              rsp_last
);

   localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_CAP);

   logic [TIME_W-1:0] period_mem [SLOT_CAP];
   logic [TIME_W-1:0] last_run_mem [SLOT_CAP];

   logic              cb_ff;
   logic [TIME_W-1:0] period_ff;
   logic [TIME_W-1:0] now_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic              out_status_ff, out_status_in;
   logic [IDX_W-1:0]  out_index_ff, out_index_in;
   logic              out_due_ff, out_due_in;
   logic              out_last_ff, out_last_in;

   logic [IDX_W-1:0]  slot;
   logic [TIME_W-1:0] elapsed;
   logic              due;
   logic              reject;
   logic              push;

   assign slot    = idx_ff[IDX_W-1:0];
   assign elapsed = now_ff - last_run_mem[slot];
   assign due     = elapsed >= period_mem[slot];
   assign reject  = !cb_ff || (period_ff == '0) || (count_ff >= SLOT_LIMIT);

   assign stat.out_free  = !out_valid_ff || rsp_ready;
   assign stat.scan_more = idx_ff < count_ff;

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      push          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_due_in    = out_due_ff;
      out_last_in   = out_last_ff;
      if (cmd.capture) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.do_reg) begin
         push          = 1'b1;
         out_kind_in   = KIND_REG;
         out_due_in    = 1'b0;
         out_last_in   = 1'b1;
         if (reject) begin
            out_status_in = STAT_REJECT;
            out_index_in  = '0;
         end else begin
            out_status_in = STAT_OK;
            out_index_in  = count_ff[IDX_W-1:0];
            count_in      = count_ff + CNT_W'(1);
         end
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (due) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = slot;
            if (pend_valid_ff) begin
               push          = 1'b1;
               out_kind_in   = KIND_RUN;
               out_status_in = STAT_OK;
               out_index_in  = pend_idx_ff;
               out_due_in    = 1'b1;
               out_last_in   = 1'b0;
            end
         end
      end
      if (cmd.scan_finish) begin
         push          = 1'b1;
         pend_valid_in = 1'b0;
         out_kind_in   = KIND_RUN;
         out_status_in = STAT_OK;
         out_index_in  = pend_valid_ff ? pend_idx_ff : '0;
         out_due_in    = pend_valid_ff;
         out_last_in   = 1'b1;
      end
      out_valid_in = push || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_due_ff    <= out_due_in;
      out_last_ff   <= out_last_in;
      if (cmd.capture) begin
         cb_ff     <= req_callback_present;
         period_ff <= req_period;
         now_ff    <= req_now_time;
      end
      if (cmd.do_reg && !reject) begin
         period_mem[count_ff[IDX_W-1:0]]   <= period_ff;
         last_run_mem[count_ff[IDX_W-1:0]] <= now_ff;
      end
      if (cmd.scan_step && due) begin
         last_run_mem[slot] <= now_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_task_index = out_index_ff;
   assign rsp_due_valid  = out_due_ff;
   assign rsp_last       = out_last_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOT_LIMIT)
      else $error("task count above slot limit");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> (!out_valid_ff || rsp_ready))
      else $error("response overwritten while held");

   a_pend_idx: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> ({1'b0, pend_idx_ff} < count_ff))
      else $error("pending due slot beyond table");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= count_ff)
      else $error("scan index past task count");

endmodule

[hw/rtl/periodic_task_dispatcher.sv]
// Periodic task dispatcher top level: controller plus datapath.
// Registration: S_REG registers the result once the response register is free; a request
// is taken only back in S_IDLE. Run scan: one step per registered task through the single
// table read port, then a closing step; each step waits while a held response is not taken.
// Synchronous reset empties the task table; table contents are not cleared.
// Depends on pdisp_pkg, pdisp_if, pdisp_ctrl and pdisp_datapath.
module periodic_task_dispatcher
   import pdisp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pdisp_req_if.sink   req_ch,
   pdisp_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   pdisp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pdisp_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_callback_present (req_ch.callback_present),
      .req_period           (req_ch.period),
      .req_now_time         (req_ch.now_time),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_kind             (rsp_ch.kind),
      .rsp_status           (rsp_ch.status),
      .rsp_task_index       (rsp_ch.task_index),
      .rsp_due_valid        (rsp_ch.due_valid),
      .rsp_last             (rsp_ch.last)
   );

endmodule

[dv/tb_periodic_task_dispatcher.sv]
// Testbench for periodic_task_dispatcher: drives register and run transactions,
// predicts every response with a scoreboard class and compares field by field.
// Depends on pdisp_pkg, pdisp_if (pdisp_req_if, pdisp_rsp_if) and the dispatcher RTL.
module tb_periodic_task_dispatcher
   import pdisp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_LIMIT   = SLOT_CAP;
   localparam int RANDOM_ITEMS = 130;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic             kind;
      logic             status;
      logic [IDX_W-1:0] task_index;
      logic             due_valid;
      logic             last;
   } dispatch_result_type;

   class dispatch_scoreboard;
      logic [CNT_W-1:0]    task_count;
      logic [TIME_W-1:0]   period_table [8];
      logic [TIME_W-1:0]   last_run_table [8];
      dispatch_result_type expected_q [$];

      function new();
         task_count = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic op, logic cb, logic [TIME_W-1:0] per,
                                 logic [TIME_W-1:0] now);
         dispatch_result_type r;
         logic [TIME_W-1:0]   elapsed;
         logic [7:0]          due_mask;
         int                  last_due;
         int                  i;
         r = '{kind: KIND_REG, status: STAT_REJECT, task_index: '0, due_valid: 1'b0,
               last: 1'b1};
         if (op == OP_REGISTER) begin
            if (cb && per != '0 && task_count < SLOT_LIMIT) begin
               period_table[task_count[IDX_W-1:0]]   = per;
               last_run_table[task_count[IDX_W-1:0]] = now;
               r.status     = STAT_OK;
               r.task_index = task_count[IDX_W-1:0];
               task_count   = task_count + CNT_W'(1);
            end
            expected_q.push_back(r);
         end else begin
            due_mask = '0;
            last_due = -1;
            for (i = 0; i < task_count && i < SLOT_LIMIT; i++) begin
               elapsed = now - last_run_table[i];
               if (elapsed >= period_table[i]) begin
                  last_run_table[i] = now;
                  due_mask[i] = 1'b1;
                  last_due = i;
               end
            end
            r.kind = KIND_RUN;
            r.status = STAT_OK;
            if (last_due < 0) begin
               expected_q.push_back(r);
            end else begin
               for (i = 0; i <= last_due; i++) begin
                  if (due_mask[i]) begin
                     r.task_index = i[IDX_W-1:0];
                     r.due_valid  = 1'b1;
                     r.last       = (i == last_due);
                     expected_q.push_back(r);
                  end
               end
            end
         end
      endfunction

      function string check_response(dispatch_result_type got);
         dispatch_result_type want;
         string               msg;
         if (expected_q.size() == 0) begin
            return $sformatf("response with nothing expected: %p", got);
         end
         want = expected_q.pop_front();
         msg = "";
         if (got.kind !== want.kind)
            msg = {msg, $sformatf(" kind %0b/%0b", got.kind, want.kind)};
         if (got.status !== want.status)
            msg = {msg, $sformatf(" status %0b/%0b", got.status, want.status)};
         if (got.task_index !== want.task_index)
            msg = {msg, $sformatf(" task_index %0d/%0d", got.task_index, want.task_index)};
         if (got.due_valid !== want.due_valid)
            msg = {msg, $sformatf(" due_valid %0b/%0b", got.due_valid, want.due_valid)};
         if (got.last !== want.last)
            msg = {msg, $sformatf(" last %0b/%0b", got.last, want.last)};
         if (msg != "") msg = {"got/expected:", msg};
         return msg;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_req = 1'b0;
   bit   calm = 1'b0;
   int   error_count = 0;
   int   idle_cycles = 0;
   int   reg_seen = 0;
   int   run_seen = 0;
   int   due_seen = 0;
   int   max_burst = 0;
   int   burst = 0;

   dispatch_scoreboard sb = new();

   pdisp_req_if req_bus ();
   pdisp_rsp_if rsp_bus ();

   periodic_task_dispatcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report(input string what);
      error_count++;
      if (error_count <= 40) $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic send_item(input logic op, input logic cb, input logic [TIME_W-1:0] per,
                            input logic [TIME_W-1:0] now);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.op               <= op;
      req_bus.callback_present <= cb;
      req_bus.period           <= per;
      req_bus.now_time         <= now;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // request side: directed transactions, then random ones, then drain
   initial begin : request_source
      logic [TIME_W-1:0] now_t;
      logic [TIME_W-1:0] per;
      int                pick;
      int                i;
      req_bus.valid            <= 1'b0;
      req_bus.op               <= OP_REGISTER;
      req_bus.callback_present <= 1'b0;
      req_bus.period           <= '0;
      req_bus.now_time         <= '0;
      wait (!reset);
      @(posedge clock);

      send_item(OP_RUN, 1'b1, 32'd7, 32'h0000_0000);
      send_item(OP_REGISTER, 1'b0, 32'd10, 32'h0000_0000);
      send_item(OP_REGISTER, 1'b1, 32'd0, 32'h0000_0000);
      send_item(OP_REGISTER, 1'b0, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_REGISTER, 1'b1, 32'd1, 32'hFFFF_FFF0);
      send_item(OP_RUN, 1'b0, 32'd0, 32'hFFFF_FFF0);
      send_item(OP_RUN, 1'b0, 32'd0, 32'hFFFF_FFF1);
      send_item(OP_REGISTER, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF2);
      send_item(OP_REGISTER, 1'b1, 32'd5, 32'hFFFF_FFFE);
      // time wraps between last runs and this scan
      send_item(OP_RUN, 1'b1, 32'hFFFF_FFFF, 32'h0000_0003);
      send_item(OP_REGISTER, 1'b1, 32'd20, 32'h0000_0004);
      send_item(OP_REGISTER, 1'b1, 32'd100, 32'h0000_0004);
      send_item(OP_REGISTER, 1'b1, 32'h8000_0000, 32'h0000_0004);
      send_item(OP_REGISTER, 1'b1, 32'd3, 32'h0000_0004);
      send_item(OP_REGISTER, 1'b1, 32'd50, 32'h0000_0004);
      // table full
      send_item(OP_REGISTER, 1'b1, 32'd7, 32'h0000_0005);
      send_item(OP_RUN, 1'b0, 32'd0, 32'h0000_0004);
      send_item(OP_RUN, 1'b0, 32'd0, 32'hFFFF_FFFF);
      // every slot due at once
      send_item(OP_RUN, 1'b0, 32'd0, 32'hFFFF_FFF1);
      send_item(OP_RUN, 1'b0, 32'd0, 32'hFFFF_FFF1);

      now_t = 32'hFFFF_FFF1;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40) hold_req <= 1'b1;
         if (i == RANDOM_ITEMS - 25) calm <= 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 60) now_t = now_t + $urandom_range(0, 30);
         else if (pick < 85) now_t = now_t + $urandom_range(0, 300);
         else if (pick < 95) now_t = now_t + $urandom();
         else now_t = $urandom();
         per = ($urandom_range(0, 4) == 0) ? '0 : $urandom();
         if ($urandom_range(0, 99) < 15)
            send_item(OP_REGISTER, 1'($urandom_range(0, 1)), per, now_t);
         else
            send_item(OP_RUN, 1'($urandom_range(0, 1)), per, now_t);
      end
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         report($sformatf("%0d expected responses never arrived", sb.pending()));
      $display("run covered %0d registrations (%0d tasks held) and %0d scans",
               reg_seen, sb.task_count, run_seen);
      $display("%0d due-task reports, up to %0d from a single scan", due_seen, max_burst);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // response side: random backpressure plus one long hold-off
   initial begin : response_sink
      int gap_left;
      int hold_left;
      bit hold_taken;
      gap_left   = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 15);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      dispatch_result_type got;
      string               msg;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind       = rsp_bus.kind;
            got.status     = rsp_bus.status;
            got.task_index = rsp_bus.task_index;
            got.due_valid  = rsp_bus.due_valid;
            got.last       = rsp_bus.last;
            msg = sb.check_response(got);
            if (msg != "") report(msg);
            if (got.due_valid) begin
               due_seen++;
               burst++;
               if (burst > max_burst) max_burst = burst;
            end
            if (got.last) burst = 0;
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.op, req_bus.callback_present, req_bus.period,
                            req_bus.now_time);
            if (req_bus.op == OP_REGISTER) reg_seen++;
            else run_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
